// ===== rtl/core/hamming_sec_encode_correct_top_assert.svh =====
// ----------------------------------------------------------------------------
// Hamming SEC assertion macros
// Implication checks for the encoder/corrector, dropped in synthesis.
// ----------------------------------------------------------------------------
`ifndef HAMMING_SEC_ENCODE_CORRECT_TOP_ASSERT_SVH
`define HAMMING_SEC_ENCODE_CORRECT_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define HSEC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hsec: same-cycle implication failed");
// Next-cycle implication.
`define HSEC_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hsec: next-cycle implication failed");
`else
`define HSEC_ASSERT_IMP(label, clk, rstn, ante, cons)
`define HSEC_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/hsec_pkg.sv =====
// ----------------------------------------------------------------------------
// hsec_pkg
// Shared types, codes and helper functions of the Hamming SEC block.
// ----------------------------------------------------------------------------
package hsec_pkg;

    localparam int WORD_W  = 38;
    localparam int DATA_W  = 32;
    localparam int SYN_W   = 6;
    localparam int CHK_W   = 3;
    localparam int LEN_W   = 6;
    localparam int CFG_W   = 6;
    localparam int CFG_IDX_W = 1;

    typedef enum logic {
        CMD_ENCODE = 1'b0,
        CMD_DECODE = 1'b1
    } hsec_cmd_t;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_CORRECTED = 2'd1;
    localparam logic [1:0] STATUS_BEYOND    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DATA_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ODD_PARITY  = 1'b1;

    localparam int DATA_LENGTH_RESET = 32;

    typedef struct packed {
        hsec_cmd_t          command;
        logic [WORD_W-1:0]  word_in;
    } hsec_in_t;

    typedef struct packed {
        logic [WORD_W-1:0]  code_word;
        logic [DATA_W-1:0]  data_bits;
        logic [SYN_W-1:0]   error_position;
        logic [1:0]         status;
        logic [CHK_W-1:0]   check_bit_count;
    } hsec_out_t;

    // Derived configuration, kept ready for the datapath.
    typedef struct packed {
        logic [CHK_W-1:0]   check_bits;
        logic [LEN_W-1:0]   code_len;
        logic               odd_parity;
    } hsec_cfg_t;

    // Least r with n + r + 1 <= 2^r.
    function automatic int hsec_check_count(int n);
        int r;
        r = 1;
        for (int i = 0; i < 6; i++) begin
            if (n + r + 1 > (1 << r)) begin
                r = r + 1;
            end
        end
        return r;
    endfunction

    // Clamp a raw data length into 1..max_data.
    function automatic int hsec_eff_len(int raw, int max_data);
        int n;
        n = raw;
        if (n < 1) begin
            n = 1;
        end
        if (n > max_data) begin
            n = max_data;
        end
        return n;
    endfunction

endpackage

// ===== rtl/core/hsec_codec.sv =====
// ----------------------------------------------------------------------------
// hsec_codec
// Combinational Hamming encode / syndrome-correct datapath for one word.
// ----------------------------------------------------------------------------
module hsec_codec
    import hsec_pkg::*;
#(
    parameter int MAX_DATA = 32
) (
    input  hsec_cfg_t cfg,
    input  hsec_in_t  item,
    output hsec_out_t result
);

    localparam int R_MAX = hsec_check_count(MAX_DATA);
    localparam int CW_W  = MAX_DATA + R_MAX;

    function automatic bit is_pow2(int p);
        return (p > 0) && ((p & (p - 1)) == 0);
    endfunction

    // Message bit index (from 0) carried by non-power position p.
    function automatic int data_index(int p);
        int k;
        k = 0;
        for (int q = 1; q < 64; q++) begin
            if (q < p && !is_pow2(q)) begin
                k = k + 1;
            end
        end
        return k;
    endfunction

    // Codeword position of message bit k (from 0).
    function automatic int data_pos(int k);
        int p;
        int cnt;
        p = 0;
        cnt = 0;
        for (int q = 1; q < 128; q++) begin
            if (!is_pow2(q)) begin
                if (cnt == k && p == 0) begin
                    p = q;
                end
                cnt = cnt + 1;
            end
        end
        return p;
    endfunction

    function automatic logic [CW_W-1:0] group_mask(int i);
        logic [CW_W-1:0] m;
        m = '0;
        for (int j = 0; j < CW_W; j++) begin
            m[j] = (((j + 1) >> i) & 1) != 0;
        end
        return m;
    endfunction

    logic [CW_W-1:0]  len_mask;
    logic [CW_W-1:0]  word_ext;
    logic [CW_W-1:0]  enc_place;
    logic [CW_W-1:0]  enc_data;
    logic [CW_W-1:0]  chk_place;
    logic [CW_W-1:0]  enc_cw;
    logic [CW_W-1:0]  rx_cw;
    logic [CW_W-1:0]  flip_sel;
    logic [CW_W-1:0]  dec_cw;
    logic [CW_W-1:0]  cw;
    logic [R_MAX-1:0] chk_en;
    logic [R_MAX-1:0] enc_par;
    logic [R_MAX-1:0] dec_par;
    logic [SYN_W-1:0] syn;
    logic             beyond;
    logic             fix_en;
    logic             is_decode;
    logic [DATA_W-1:0] data_out;
    logic [WORD_W-1:0] cw_out;

    assign is_decode = (item.command == CMD_DECODE);

    for (genvar j = 0; j < CW_W; j++) begin : g_pos
        assign len_mask[j] = (LEN_W'(j + 1) <= cfg.code_len);
        if (j < WORD_W) begin : g_w
            assign word_ext[j] = item.word_in[j];
        end else begin : g_wz
            assign word_ext[j] = 1'b0;
        end
        if (is_pow2(j + 1)) begin : g_chk
            assign enc_place[j] = 1'b0;
            assign chk_place[j] = enc_par[$clog2(j + 1)] & chk_en[$clog2(j + 1)];
        end else begin : g_dat
            assign chk_place[j] = 1'b0;
            if (data_index(j + 1) < WORD_W) begin : g_in
                assign enc_place[j] = item.word_in[data_index(j + 1)];
            end else begin : g_inz
                assign enc_place[j] = 1'b0;
            end
        end
        assign flip_sel[j] = (syn == SYN_W'(j + 1));
    end

    // Parity groups; the check position itself is zero in enc_data.
    assign enc_data = enc_place & len_mask;
    assign rx_cw    = word_ext & len_mask;

    for (genvar i = 0; i < R_MAX; i++) begin : g_grp
        assign chk_en[i]  = (cfg.check_bits > CHK_W'(i));
        assign enc_par[i] = (^(enc_data & group_mask(i))) ^ cfg.odd_parity;
        assign dec_par[i] = (^(rx_cw & group_mask(i))) ^ cfg.odd_parity;
    end

    for (genvar i = 0; i < SYN_W; i++) begin : g_syn
        if (i < R_MAX) begin : g_s
            assign syn[i] = dec_par[i] & chk_en[i];
        end else begin : g_sz
            assign syn[i] = 1'b0;
        end
    end

    assign enc_cw = enc_data | chk_place;
    assign beyond = (syn > cfg.code_len);
    assign fix_en = (syn != '0) && !beyond;
    assign dec_cw = rx_cw ^ (flip_sel & {CW_W{fix_en}});
    assign cw     = is_decode ? dec_cw : enc_cw;

    for (genvar k = 0; k < DATA_W; k++) begin : g_ext
        if (data_pos(k) <= CW_W) begin : g_d
            assign data_out[k] = cw[data_pos(k) - 1];
        end else begin : g_dz
            assign data_out[k] = 1'b0;
        end
    end

    for (genvar j = 0; j < WORD_W; j++) begin : g_cwo
        if (j < CW_W) begin : g_c
            assign cw_out[j] = cw[j];
        end else begin : g_cz
            assign cw_out[j] = 1'b0;
        end
    end

    always_comb begin
        result.code_word       = cw_out;
        result.data_bits       = data_out;
        result.check_bit_count = cfg.check_bits;
        result.error_position  = is_decode ? syn : '0;
        if (!is_decode || syn == '0) begin
            result.status = STATUS_OK;
        end else if (beyond) begin
            result.status = STATUS_BEYOND;
        end else begin
            result.status = STATUS_CORRECTED;
        end
    end

endmodule

// ===== rtl/core/hamming_sec_encode_correct_top.sv =====
// ----------------------------------------------------------------------------
// hamming_sec_encode_correct_top
// Pipeline: input register, then result register behind one pass of parity
//   trees and correction.
// Throughput: one beat per cycle unless stalled, set by the two-register pipeline.
// Reset: synchronous active-low; clears valids, data_length 32, even parity.
// ----------------------------------------------------------------------------
`include "hamming_sec_encode_correct_top_assert.svh"

module hamming_sec_encode_correct_top
    import hsec_pkg::*;
#(
    parameter int MAX_DATA = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // Input channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  hsec_in_t             s_data,
    // Result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output hsec_out_t            m_data
);

    // Reset values of the derived configuration.
    localparam int RST_N   = hsec_eff_len(DATA_LENGTH_RESET, MAX_DATA);
    localparam int RST_R   = hsec_check_count(RST_N);
    localparam int RST_LEN = RST_N + RST_R;

    // Configuration is held in derived form: check-bit count, codeword
    // length and parity sense, so the datapath sees only ready values.
    hsec_cfg_t cfg_reg, cfg_next;
    int        wr_n;
    int        wr_r;

    always_comb begin
        wr_n     = hsec_eff_len(int'(cfg_wdata), MAX_DATA);
        wr_r     = hsec_check_count(wr_n);
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_DATA_LENGTH: begin
                    cfg_next.check_bits = CHK_W'(wr_r);
                    cfg_next.code_len   = LEN_W'(wr_n + wr_r);
                end
                CFG_ODD_PARITY: begin
                    cfg_next.odd_parity = cfg_wdata[0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.check_bits <= CHK_W'(RST_R);
            cfg_reg.code_len   <= LEN_W'(RST_LEN);
            cfg_reg.odd_parity <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Two-stage pipeline: input register, then result register. Both
    // advance together whenever the result slot is empty or being drained,
    // so a fresh beat is taken every cycle while results flow.
    logic      in_valid_reg, in_valid_next;
    hsec_in_t  in_data_reg, in_data_next;
    logic      m_valid_reg, m_valid_next;
    hsec_out_t m_data_reg, m_data_next;
    hsec_out_t codec_result;
    logic      advance;
    logic      s_take;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance || !in_valid_reg;
    assign s_take  = s_valid && s_ready;

    hsec_codec #(
        .MAX_DATA (MAX_DATA)
    ) u_codec (
        .cfg    (cfg_reg),
        .item   (in_data_reg),
        .result (codec_result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        in_data_next  = in_data_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        // Advance the finished word into the result slot.
        if (advance) begin
            m_valid_next = in_valid_reg;
            if (in_valid_reg) begin
                m_data_next = codec_result;
            end
        end
        // Load a new beat, or drop the input stage once it has moved on.
        if (s_take) begin
            in_valid_next = 1'b1;
            in_data_next  = s_data;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        in_data_reg <= in_data_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A word in the input stage reaches the result slot on advance.
    `HSEC_ASSERT_NXT(a_stage_advance, aclk, aresetn, in_valid_reg && advance, m_valid_reg)
    // A blocked input stage holds its word.
    `HSEC_ASSERT_NXT(a_stage_hold, aclk, aresetn, in_valid_reg && !advance, in_valid_reg && $stable(in_data_reg))
    // Clean result carries a zero syndrome.
    `HSEC_ASSERT_IMP(a_clean_zero_syn, aclk, aresetn, m_valid_reg && m_data_reg.status == STATUS_OK, m_data_reg.error_position == '0)
    // Any reported error carries a nonzero syndrome.
    `HSEC_ASSERT_IMP(a_error_has_syn, aclk, aresetn, m_valid_reg && (m_data_reg.status == STATUS_CORRECTED || m_data_reg.status == STATUS_BEYOND), m_data_reg.error_position != '0)

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: Hamming SEC encoder/corrector testbench
// Drives encode and decode beats into the block at several data lengths and
// both parity senses. Each result beat is checked, field by field, against
// an in-line model of the code. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top
    import hsec_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DATA      = 32;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 8;   // extra settle time after the last result
    localparam int RANDOM_BEATS  = 42;  // per configuration phase

    // Clock, reset and block ports; every input starts at a known value.
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_DATA_LENGTH;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    hsec_in_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    hsec_out_t            m_data;

    // Model copy of the two registers, as written.
    logic [5:0] model_data_length = 6'(DATA_LENGTH_RESET);
    logic       model_odd_parity  = 1'b0;

    // Results the block still owes us, oldest first.
    hsec_out_t awaited_words[$];

    // Sender burst state; a phase may switch idling off.
    int  burst_left   = 0;
    bit  sender_eager = 1'b0;

    // Run statistics.
    int  mismatch_count  = 0;
    int  beats_checked   = 0;
    int  encodes_seen    = 0;
    int  corrected_seen  = 0;
    int  beyond_seen     = 0;
    int  phase_count     = 0;
    int  cycle_count     = 0;

    hamming_sec_encode_correct_top #(
        .MAX_DATA (MAX_DATA)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Model of the code: clamp the length, find the check-bit count, then
    // either build the codeword or compute the syndrome and repair it.
    // ------------------------------------------------------------------
    function automatic int clamped_length(input logic [5:0] len_reg);
        int n;
        n = int'(len_reg);
        if (n < 1) begin
            n = 1;
        end
        if (n > MAX_DATA) begin
            n = MAX_DATA;
        end
        return n;
    endfunction

    function automatic hsec_out_t hamming_compute(input hsec_in_t item,
                                                  input logic [5:0] len_reg,
                                                  input logic odd);
        hsec_out_t   res;
        int          n;
        int          r;
        int          span;
        int          k;
        int          syn;
        int          x;
        logic [63:0] msg;
        logic [63:0] cw;
        logic        acc;

        res  = '0;
        n    = clamped_length(len_reg);
        r    = 1;
        while (n + r + 1 > (1 << r)) begin
            r++;
        end
        span = n + r;
        cw   = '0;
        syn  = 0;

        if (item.command == CMD_ENCODE) begin
            // Message bits fill the non-power-of-two positions in order.
            msg = 64'(item.word_in) & ((64'd1 << n) - 64'd1);
            k   = 0;
            for (int p = 1; p <= span; p++) begin
                if ((p & (p - 1)) != 0) begin
                    cw[p-1] = msg[k];
                    k++;
                end
            end
            for (int i = 0; i < r; i++) begin
                x   = 1 << i;
                acc = odd;
                for (int p = 1; p <= span; p++) begin
                    if ((p & x) != 0 && p != x) begin
                        acc ^= cw[p-1];
                    end
                end
                cw[x-1] = acc;
            end
            res.status = STATUS_OK;
        end else begin
            // Bits above the codeword length never reach the syndrome.
            cw = 64'(item.word_in) & ((64'd1 << span) - 64'd1);
            for (int i = 0; i < r; i++) begin
                x   = 1 << i;
                acc = 1'b0;
                for (int p = 1; p <= span; p++) begin
                    if ((p & x) != 0) begin
                        acc ^= cw[p-1];
                    end
                end
                if (acc != odd) begin
                    syn += x;
                end
            end
            if (syn == 0) begin
                res.status = STATUS_OK;
            end else if (syn <= span) begin
                cw[syn-1]  = ~cw[syn-1];
                res.status = STATUS_CORRECTED;
            end else begin
                // Syndrome points past the word: report it, flip nothing.
                res.status = STATUS_BEYOND;
            end
        end

        k = 0;
        for (int p = 1; p <= span; p++) begin
            if ((p & (p - 1)) != 0) begin
                res.data_bits[k] = cw[p-1];
                k++;
            end
        end
        res.code_word       = cw[WORD_W-1:0];
        res.error_position  = SYN_W'(syn);
        res.check_bit_count = CHK_W'(r);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting: one line each, and every mismatch is counted.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("tb_top: mismatch, %s at result %0d: got %h, want %h",
                 what, beats_checked, got, want);
    endtask

    // ------------------------------------------------------------------
    // Result checker: sample at the edge, before any update of this step
    // lands, and compare each accepted beat with the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        hsec_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_words.size() == 0) begin
                report_mismatch("result beat with nothing pending",
                                64'(m_data.code_word), 64'd0);
            end else begin
                want = awaited_words.pop_front();
                if (m_data.code_word !== want.code_word) begin
                    report_mismatch("code_word", 64'(m_data.code_word),
                                    64'(want.code_word));
                end
                if (m_data.data_bits !== want.data_bits) begin
                    report_mismatch("data_bits", 64'(m_data.data_bits),
                                    64'(want.data_bits));
                end
                if (m_data.error_position !== want.error_position) begin
                    report_mismatch("error_position", 64'(m_data.error_position),
                                    64'(want.error_position));
                end
                if (m_data.status !== want.status) begin
                    report_mismatch("status", 64'(m_data.status),
                                    64'(want.status));
                end
                if (m_data.check_bit_count !== want.check_bit_count) begin
                    report_mismatch("check_bit_count", 64'(m_data.check_bit_count),
                                    64'(want.check_bit_count));
                end
                if (want.status == STATUS_CORRECTED) begin
                    corrected_seen++;
                end
                if (want.status == STATUS_BEYOND) begin
                    beyond_seen++;
                end
            end
            beats_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Receiver back-pressure: the pattern steps in turn through four modes -
    // always ready, mostly ready, coin flip, and long stalls with short
    // open windows.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        case ((cycle_count >> 7) % 4)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= ($urandom_range(0, 3) != 0);
            end
            2: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
                m_ready <= ((cycle_count % 16) < 5);
            end
        endcase
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: timeout after %0d cycles", cycle_count);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Send one beat. Valid stays high across a burst; between bursts, drop
    // it for a random gap. The expectation is queued at acceptance.
    // ------------------------------------------------------------------
    task automatic send_beat(input hsec_in_t item);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = sender_eager ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        burst_left--;
        awaited_words.push_back(hamming_compute(item, model_data_length,
                                                model_odd_parity));
        if (item.command == CMD_ENCODE) begin
            encodes_seen++;
        end
    endtask

    // Drop valid, let every pending result drain, then let the pipeline
    // settle before anything touches the registers.
    task automatic wait_for_idle();
        s_valid    <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (awaited_words.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Single-cycle register write; the model copy follows the mask of each
    // register.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_DATA_LENGTH) begin
            model_data_length = value;
        end else begin
            model_odd_parity = value[0];
        end
        @(posedge aclk);
    endtask

    // Both registers; the parity write carries random upper bits that the
    // block must mask off.
    task automatic set_code(input logic [5:0] len_raw, input logic odd);
        wait_for_idle();
        write_register(CFG_DATA_LENGTH, len_raw);
        write_register(CFG_ODD_PARITY, {5'($urandom_range(0, 31)), odd});
        phase_count++;
    endtask

    function automatic hsec_in_t make_beat(input hsec_cmd_t cmd,
                                           input logic [WORD_W-1:0] word);
        hsec_in_t item;
        item.command = cmd;
        item.word_in = word;
        return item;
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[WORD_W-1:0];
    endfunction

    // Valid codeword for a message under the current settings.
    function automatic logic [WORD_W-1:0] codeword_of(input logic [WORD_W-1:0] msg);
        hsec_out_t enc;
        enc = hamming_compute(make_beat(CMD_ENCODE, msg), model_data_length,
                              model_odd_parity);
        return enc.code_word;
    endfunction

    // ------------------------------------------------------------------
    // Directed: field extremes, both commands, single-bit repairs on data
    // and check positions, syndromes past the word, ignored high bits and
    // out-of-range data lengths.
    // ------------------------------------------------------------------
    task automatic test_directed();
        logic [WORD_W-1:0] good;

        // Reset settings: 32 message bits, 6 check bits, even parity.
        send_beat(make_beat(CMD_ENCODE, '0));
        send_beat(make_beat(CMD_ENCODE, '1));
        send_beat(make_beat(CMD_ENCODE, 38'h1));
        send_beat(make_beat(CMD_ENCODE, 38'h0_8000_0000));
        send_beat(make_beat(CMD_ENCODE, 38'h0_A5A5_A5A5));
        send_beat(make_beat(CMD_DECODE, '0));
        send_beat(make_beat(CMD_DECODE, '1));
        good = codeword_of(38'h0_DEAD_BEEF);
        send_beat(make_beat(CMD_DECODE, good));
        send_beat(make_beat(CMD_DECODE, good ^ 38'h1));             // check bit 1
        send_beat(make_beat(CMD_DECODE, good ^ (38'h1 << 37)));     // last position
        send_beat(make_beat(CMD_DECODE, good ^ 38'h4));             // first data bit
        send_beat(make_beat(CMD_DECODE, good ^ (38'h1 << 31)));     // check bit 32
        // Positions 31 and 32 together give syndrome 63, past the word.
        send_beat(make_beat(CMD_DECODE, 38'h0_C000_0000));

        // Length zero is taken as one; odd parity; high bits must be dropped.
        set_code(6'd0, 1'b1);
        send_beat(make_beat(CMD_ENCODE, '0));
        send_beat(make_beat(CMD_ENCODE, '1));
        send_beat(make_beat(CMD_DECODE, '0));
        send_beat(make_beat(CMD_DECODE, '1));

        // Length above the maximum is taken as the maximum; with odd parity
        // an all-zero word has every check failing.
        set_code(6'd63, 1'b1);
        send_beat(make_beat(CMD_DECODE, '0));
        send_beat(make_beat(CMD_ENCODE, '1));
        send_beat(make_beat(CMD_DECODE, codeword_of(38'h0_1234_5678) ^ 38'h100));
    endtask

    // ------------------------------------------------------------------
    // Random traffic at the current settings. Most decodes are real
    // codewords with zero, one or two flips; the rest are raw noise. Bits
    // above the codeword are often set to prove they are ignored.
    // ------------------------------------------------------------------
    task automatic test_random_traffic(input int count);
        int                n;
        int                span;
        int                kind;
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] high_junk;
        hsec_out_t         probe;

        n     = clamped_length(model_data_length);
        probe = hamming_compute(make_beat(CMD_ENCODE, '0), model_data_length,
                                model_odd_parity);
        span  = n + probe.check_bit_count;
        for (int i = 0; i < count; i++) begin
            kind      = $urandom_range(0, 9);
            high_junk = random_word() & ~((38'h1 << span) - 38'h1);
            if (span >= WORD_W) begin
                high_junk = '0;
            end
            if (kind <= 2) begin
                send_beat(make_beat(CMD_ENCODE, random_word()));
            end else if (kind == 9) begin
                send_beat(make_beat(CMD_DECODE, random_word()));
            end else begin
                word = codeword_of(random_word());
                if (kind >= 4) begin
                    word[$urandom_range(0, span - 1)] ^= 1'b1;
                end
                if (kind >= 7) begin
                    word[$urandom_range(0, span - 1)] ^= 1'b1;
                end
                if ($urandom_range(0, 1)) begin
                    word |= high_junk;
                end
                send_beat(make_beat(CMD_DECODE, word));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sweep the settings: shortest and longest codes, the length breaks
    // where the check-bit count steps, and both parity senses. Every third
    // phase runs the sender without gaps.
    // ------------------------------------------------------------------
    task automatic test_length_sweep();
        logic [5:0] lengths[12] = '{6'd32, 6'd1, 6'd1, 6'd2, 6'd4, 6'd5,
                                    6'd11, 6'd12, 6'd26, 6'd27, 6'd57, 6'd63};
        for (int ph = 0; ph < 12; ph++) begin
            set_code(lengths[ph], 1'(ph % 2));
            sender_eager = (ph % 3 == 2);
            test_random_traffic(RANDOM_BEATS);
        end
        sender_eager = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset once, then the tests in turn, drain and verdict.
    // ------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_length_sweep();

        wait_for_idle();

        $display("tb_top: %0d results checked (%0d encodes), %0d repairs, %0d past-end syndromes",
                 beats_checked, encodes_seen, corrected_seen, beyond_seen);
        $display("tb_top: %0d register settings exercised, %0d mismatches",
                 phase_count, mismatch_count);
        if (mismatch_count == 0 && awaited_words.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
